>>> src/clp_pkg.sv
// Shared types, constants and helpers of the charlieplexed LED PWM driver.
package clp_pkg;

	localparam int LED_NUM      = 12;
	localparam int PIN_NUM      = 4;
	localparam int BRIGHT_W     = 6;
	localparam int MAP_W        = 48;
	localparam int PWM_BITS_DEF = 6;
	localparam int RAMP_OUT_W   = 6;

	localparam logic [MAP_W-1:0] PIN_MAP_RST = 48'h3C7D_EB28_6914;
	localparam logic [MAP_W-1:0] GROUP_RST   = 48'hB967_5382_1A40;

	typedef logic [BRIGHT_W-1:0] bright_t;
	typedef bright_t bright_arr_t [LED_NUM];

	localparam bright_arr_t BRIGHT_INIT = '{
		6'd16, 6'd63, 6'd32, 6'd16, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd1
	};

	// Configuration register indexes.
	localparam logic REG_PIN_MAP = 1'b0;
	localparam logic REG_GROUP   = 1'b1;

	// Input word kinds, carried on tuser.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef struct packed {
		logic [PIN_NUM-1:0] en;  // 1 = driven
		logic [PIN_NUM-1:0] val; // output latch, kept while floating
	} pin_state_t;

	function automatic logic [3:0] nib(input logic [MAP_W-1:0] word, input logic [3:0] idx);
		return word[{idx, 2'b00} +: 4];
	endfunction

	function automatic logic [3:0] slot_led(input logic [MAP_W-1:0] members,
			input logic [1:0] grp, input logic [1:0] slot);
		return nib(members, 4'({2'b00, grp} * 4'd3 + {2'b00, slot}));
	endfunction

	function automatic logic [PIN_NUM-1:0] pin_bit(input logic [1:0] pin);
		return PIN_NUM'(1) << pin;
	endfunction

endpackage

>>> src/clp_bright_bank.sv
// Brightness registers of the twelve LEDs and their compare against the ramp.
module clp_bright_bank #(
	parameter int PWM_BITS = clp_pkg::PWM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [3:0]                    wr_idx,
	input  clp_pkg::bright_t              wr_val,
	input  logic [PWM_BITS-1:0]           ramp,
	output logic [clp_pkg::LED_NUM-1:0]   match
);
	import clp_pkg::*;

	localparam int CMP_W = (PWM_BITS > BRIGHT_W) ? PWM_BITS : BRIGHT_W;

	bright_t bright_q [LED_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_INIT;
		end else if (wr_en && (wr_idx < 4'(LED_NUM))) begin
			bright_q[wr_idx] <= wr_val;
		end
	end

	// One equality compare per LED; the pin step picks the ones it needs.
	always_comb begin
		for (int i = 0; i < LED_NUM; i++) begin
			match[i] = (CMP_W'(bright_q[i]) == CMP_W'(ramp));
		end
	end

endmodule

>>> src/clp_pin_step.sv
// Next pin drive state and cathode group for one PWM tick.
module clp_pin_step (
	input  logic [clp_pkg::MAP_W-1:0]   pin_map,
	input  logic [clp_pkg::MAP_W-1:0]   members,
	input  logic                        wrap,
	input  logic [1:0]                  grp,
	input  clp_pkg::pin_state_t         pins,
	input  logic [clp_pkg::LED_NUM-1:0] match,
	output logic [1:0]                  grp_next,
	output clp_pkg::pin_state_t         pins_next
);
	import clp_pkg::*;

	always_comb begin
		logic [3:0]         led;
		logic [3:0]         desc;
		logic [1:0]         g;
		logic [PIN_NUM-1:0] en;
		logic [PIN_NUM-1:0] val;

		led  = '0;
		desc = '0;
		g    = grp;
		en   = pins.en;
		val  = pins.val;

		if (wrap) begin
			// float the old cathode, step the group, pull the new cathode low
			led = slot_led(members, g, 2'd0);
			if (led < 4'(LED_NUM)) begin
				desc = nib(pin_map, led);
				en   = en & ~pin_bit(desc[1:0]);
			end
			g   = g + 2'd1;
			led = slot_led(members, g, 2'd0);
			if (led < 4'(LED_NUM)) begin
				desc = nib(pin_map, led);
				en   = en | pin_bit(desc[1:0]);
				val  = val & ~pin_bit(desc[1:0]);
			end
			// drive all anodes of the new group high
			for (int s = 0; s < 3; s++) begin
				led = slot_led(members, g, 2'(s));
				if (led < 4'(LED_NUM)) begin
					desc = nib(pin_map, led);
					en   = en | pin_bit(desc[3:2]);
					val  = val | pin_bit(desc[3:2]);
				end
			end
		end

		// end of on-time: float the anode of each LED whose brightness hits the ramp
		for (int s = 0; s < 3; s++) begin
			led = slot_led(members, g, 2'(s));
			if (led < 4'(LED_NUM)) begin
				if (match[led]) begin
					desc = nib(pin_map, led);
					en   = en & ~pin_bit(desc[3:2]);
				end
			end
		end

		grp_next      = g;
		pins_next.en  = en;
		pins_next.val = val;
	end

endmodule

>>> src/charlieplex_pwm_led_driver_unit.sv
// Top level of the charlieplexed LED PWM driver: input stage, state and result register.
//
//  channel  | direction | payload (low bit first)
//  ---------+-----------+---------------------------------------------------------
//  s_*      | in        | tuser: mode; tdata: led_index[3:0], brightness_value[9:4]
//  m_*      | out       | tdata: pin_drive, pin_level, active_group, ramp_phase
//  cfg_*    | in        | cfg_index 0 = led_pin_map, 1 = group_members
//
// One word per cycle unless the master side stalls: a word is taken into the input stage, and
// when it advances its tick or brightness write commits and its result is loaded into the output register.
// The path from input stage to result is the ramp increment, the twelve brightness
// compares and the pin update of one cathode group.
// Reset clears the ramp, group and pins and restores the default brightness table
// and pin maps. A stall on the master side holds the result and the input stage;
// the slave side keeps flowing while the output register is being drained.
module charlieplex_pwm_led_driver_unit #(
	parameter int PWM_BITS = clp_pkg::PWM_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// slave side
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,  // led_index[3:0], brightness_value[9:4], zero
	input  logic [0:0]                s_tuser,  // mode[0]
	// master side
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,  // pin_drive[3:0], pin_level[7:4],
	                                            // active_group[9:8], ramp_phase[15:10]
	// configuration
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [clp_pkg::MAP_W-1:0] cfg_data
);
	import clp_pkg::*;

	localparam int EXT_W = (PWM_BITS > RAMP_OUT_W) ? PWM_BITS : RAMP_OUT_W;

	// configuration registers
	logic [MAP_W-1:0] pin_map_q;
	logic [MAP_W-1:0] members_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_map_q <= PIN_MAP_RST;
			members_q <= GROUP_RST;
		end else if (cfg_we) begin
			case (cfg_index[0])
				REG_PIN_MAP: pin_map_q <= cfg_data;
				REG_GROUP:   members_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic       mode_s1;
	logic [3:0] idx_s1;
	bright_t    val_s1;
	logic       advance;

	// commit the staged word when the result register is free or being drained
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser[0];
			idx_s1  <= s_tdata[3:0];
			val_s1  <= s_tdata[9:4];
		end
	end

	// block state
	logic [PWM_BITS-1:0] tick_q;
	logic [1:0]          group_q;
	pin_state_t          pins_q;

	logic                tick_go;
	logic [PWM_BITS-1:0] tick_next;
	logic                wrap;
	logic [LED_NUM-1:0]  match;
	logic [1:0]          group_next;
	pin_state_t          pins_next;

	assign tick_go   = advance && (mode_s1 == MODE_TICK);
	assign tick_next = tick_q + PWM_BITS'(1);
	assign wrap      = (tick_next == '0);

	clp_bright_bank #(
		.PWM_BITS(PWM_BITS)
	) u_bright (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (advance && (mode_s1 == MODE_WRITE)),
		.wr_idx (idx_s1),
		.wr_val (val_s1),
		.ramp   (tick_next),
		.match  (match)
	);

	clp_pin_step u_step (
		.pin_map   (pin_map_q),
		.members   (members_q),
		.wrap      (wrap),
		.grp       (group_q),
		.pins      (pins_q),
		.match     (match),
		.grp_next  (group_next),
		.pins_next (pins_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			group_q <= 2'd0;
			pins_q  <= '0;
		end else if (tick_go) begin
			tick_q  <= tick_next;
			group_q <= group_next;
			pins_q  <= pins_next;
		end
	end

	// result register: state after the committed word
	logic [3:0]            drive_now;
	logic [3:0]            level_now;
	logic [1:0]            group_now;
	logic [PWM_BITS-1:0]   ramp_now;
	logic [EXT_W-1:0]      ramp_ext;
	logic [15:0]           out_q;
	logic                  out_valid_q;

	always_comb begin
		if (tick_go) begin
			drive_now = pins_next.en;
			level_now = pins_next.val & pins_next.en;
			group_now = group_next;
			ramp_now  = tick_next;
		end else begin
			drive_now = pins_q.en;
			level_now = pins_q.val & pins_q.en;
			group_now = group_q;
			ramp_now  = tick_q;
		end
		ramp_ext = EXT_W'(ramp_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {ramp_ext[RAMP_OUT_W-1:0], group_now, level_now, drive_now};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
